### rtl/psia_pkg.sv
// Shared types and codes for the paged session ID allocator.
`default_nettype none

package psia_pkg;

    // Width of the session ID and of the returned handle on the ports.
    localparam int ID_BITS      = 16;
    localparam int OUT_HDL_BITS = 32;

    // Operation codes.
    localparam logic [1:0] FN_ADD    = 2'd0;
    localparam logic [1:0] FN_REMOVE = 2'd1;
    localparam logic [1:0] FN_FIND   = 2'd2;

    // Status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_LIMIT     = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_MISMATCH  = 2'd3;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_ISSUE,
        S_PAGE,
        S_SWEEP,
        S_SLOT_RD,
        S_SLOT,
        S_PWRITE,
        S_NXT,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

### rtl/psia_ram.sv
// Simple dual-port synchronous RAM with one write port and one registered read port.
`default_nettype none

module psia_ram #(
    parameter int ADDR_BITS = 7,
    parameter int DATA_BITS = 8
) (
    input  wire logic                 clk,
    input  wire logic                 we,
    input  wire logic [ADDR_BITS-1:0] waddr,
    input  wire logic [DATA_BITS-1:0] wdata,
    input  wire logic [ADDR_BITS-1:0] raddr,
    output logic      [DATA_BITS-1:0] rdata
);

    logic [DATA_BITS-1:0] mem [2**ADDR_BITS];
    logic [DATA_BITS-1:0] rdata_reg;

    // Write and registered read; read data appears in the cycle after the address.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### rtl/psia_ctrl.sv
// Sequencer for the allocator: page and slot read-modify-write, page bring-in and result buffer.
`default_nettype none

module psia_ctrl #(
    parameter int PAGE_BITS   = 7,
    parameter int SLOT_BITS   = 9,
    parameter int HANDLE_BITS = 32,
    parameter int PW          = 28,
    parameter int SW          = 43
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic [1:0]                       func,
    input  wire logic [psia_pkg::ID_BITS-1:0]     session_id,
    input  wire logic [HANDLE_BITS-1:0]           handle,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic [1:0]                            status,
    output logic [psia_pkg::ID_BITS-1:0]          assigned_id,
    output logic [psia_pkg::OUT_HDL_BITS-1:0]     found_handle,
    output logic                                  pg_we,
    output logic [PAGE_BITS-1:0]                  pg_waddr,
    output logic [PW-1:0]                         pg_wdata,
    output logic [PAGE_BITS-1:0]                  pg_raddr,
    input  wire logic [PW-1:0]                    pg_rdata,
    output logic                                  sl_we,
    output logic [PAGE_BITS+SLOT_BITS-1:0]        sl_waddr,
    output logic [SW-1:0]                         sl_wdata,
    output logic [PAGE_BITS+SLOT_BITS-1:0]        sl_raddr,
    input  wire logic [SW-1:0]                    sl_rdata
);

    localparam int PMAX = 2**PAGE_BITS;
    localparam int SMAX = 2**SLOT_BITS;
    localparam int CW   = (PAGE_BITS > SLOT_BITS) ? PAGE_BITS : SLOT_BITS;

    psia_pkg::state_t state_reg, state_next;

    logic [1:0]               func_reg,   func_next;
    logic [PAGE_BITS-1:0]     page_reg,   page_next;
    logic [SLOT_BITS-1:0]     slot_reg,   slot_next;
    logic [HANDLE_BITS-1:0]   hdl_reg,    hdl_next;
    logic [PAGE_BITS:0]       pnext_reg,  pnext_next;
    logic [SLOT_BITS:0]       puse_reg,   puse_next;
    logic [SLOT_BITS:0]       pfsh_reg,   pfsh_next;
    logic [PAGE_BITS:0]       head_reg,   head_next;
    logic [PAGE_BITS:0]       nxt_reg,    nxt_next;
    logic [CW-1:0]            cnt_reg,    cnt_next;
    logic [PMAX-1:0]          present_reg, present_next;
    logic [1:0]               rstat_reg,  rstat_next;
    logic [psia_pkg::ID_BITS-1:0]      rid_reg,  rid_next;
    logic [psia_pkg::OUT_HDL_BITS-1:0] rhdl_reg, rhdl_next;
    logic                              ovalid_reg, ovalid_next;
    logic [1:0]                        ostat_reg,  ostat_next;
    logic [psia_pkg::ID_BITS-1:0]      oid_reg,    oid_next;
    logic [psia_pkg::OUT_HDL_BITS-1:0] ohdl_reg,   ohdl_next;

    // Fields of the read data.
    logic [PAGE_BITS:0]     pr_next;
    logic [SLOT_BITS:0]     pr_use;
    logic [SLOT_BITS:0]     pr_fsh;
    logic [SLOT_BITS:0]     sr_next;
    logic                   sr_occ;
    logic [HANDLE_BITS-1:0] sr_hdl;
    logic [SLOT_BITS:0]     rm_use;
    logic                   rm_ok;
    logic                   rm_wrap;
    logic                   out_free;
    logic [31:0]            id_ext;
    logic [63:0]            hdl_ext;
    logic [31:0]            asg_ext;

    assign {pr_next, pr_use, pr_fsh} = pg_rdata;
    assign {sr_next, sr_occ, sr_hdl} = sl_rdata;
    assign rm_use   = pr_use - (SLOT_BITS+1)'(1);
    assign rm_ok    = sr_occ && (sr_hdl == hdl_reg);
    assign rm_wrap  = rm_use == (SLOT_BITS+1)'(SMAX - 1);
    assign out_free = !ovalid_reg || out_ready;
    assign id_ext   = 32'(session_id);
    assign hdl_ext  = 64'(sr_hdl);
    assign asg_ext  = (32'(page_reg) << SLOT_BITS) | 32'(pfsh_reg[SLOT_BITS-1:0]);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            psia_pkg::S_INIT:
            begin
                if (&cnt_reg)
                begin
                    state_next = psia_pkg::S_IDLE;
                end
            end
            psia_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = psia_pkg::S_ISSUE;
                end
            end
            psia_pkg::S_ISSUE:
            begin
                priority if (func_reg == psia_pkg::FN_ADD)
                begin
                    state_next = head_reg[PAGE_BITS] ? psia_pkg::S_DONE : psia_pkg::S_PAGE;
                end
                else if (func_reg == psia_pkg::FN_REMOVE || func_reg == psia_pkg::FN_FIND)
                begin
                    state_next = present_reg[page_reg] ? psia_pkg::S_PAGE : psia_pkg::S_DONE;
                end
                else
                begin
                    state_next = psia_pkg::S_DONE;
                end
            end
            psia_pkg::S_PAGE:
            begin
                priority if (func_reg == psia_pkg::FN_ADD)
                begin
                    state_next = present_reg[page_reg] ? psia_pkg::S_SLOT_RD
                                                       : psia_pkg::S_SWEEP;
                end
                else if (func_reg == psia_pkg::FN_REMOVE && rm_ok && rm_wrap
                         && !head_reg[PAGE_BITS])
                begin
                    state_next = psia_pkg::S_NXT;
                end
                else
                begin
                    state_next = psia_pkg::S_DONE;
                end
            end
            psia_pkg::S_SWEEP:
            begin
                if (&cnt_reg[SLOT_BITS-1:0])
                begin
                    state_next = psia_pkg::S_SLOT_RD;
                end
            end
            psia_pkg::S_SLOT_RD:
            begin
                state_next = pfsh_reg[SLOT_BITS] ? psia_pkg::S_PWRITE : psia_pkg::S_SLOT;
            end
            psia_pkg::S_SLOT:   state_next = psia_pkg::S_PWRITE;
            psia_pkg::S_PWRITE: state_next = psia_pkg::S_DONE;
            psia_pkg::S_NXT:    state_next = psia_pkg::S_DONE;
            psia_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    state_next = psia_pkg::S_IDLE;
                end
            end
            default: state_next = psia_pkg::S_IDLE;
        endcase
    end

    // Datapath, memory ports and result.
    always_comb
    begin
        func_next    = func_reg;
        page_next    = page_reg;
        slot_next    = slot_reg;
        hdl_next     = hdl_reg;
        pnext_next   = pnext_reg;
        puse_next    = puse_reg;
        pfsh_next    = pfsh_reg;
        head_next    = head_reg;
        nxt_next     = nxt_reg;
        cnt_next     = cnt_reg;
        present_next = present_reg;
        rstat_next   = rstat_reg;
        rid_next     = rid_reg;
        rhdl_next    = rhdl_reg;
        ovalid_next  = ovalid_reg && !out_ready;
        ostat_next   = ostat_reg;
        oid_next     = oid_reg;
        ohdl_next    = ohdl_reg;
        pg_we        = 1'b0;
        pg_waddr     = page_reg;
        pg_wdata     = {pnext_reg, puse_reg, pfsh_reg};
        pg_raddr     = page_reg;
        sl_we        = 1'b0;
        sl_waddr     = {page_reg, slot_reg};
        sl_wdata     = sl_rdata;
        sl_raddr     = {page_reg, slot_reg};
        unique case (state_reg)
            psia_pkg::S_INIT:
            begin
                // Set up the page table and the slot links of page zero.
                cnt_next = cnt_reg + CW'(1);
                pg_we    = (cnt_reg >> PAGE_BITS) == '0;
                pg_waddr = cnt_reg[PAGE_BITS-1:0];
                pg_wdata = {(PAGE_BITS+1)'(cnt_reg[PAGE_BITS-1:0]) + (PAGE_BITS+1)'(1),
                            (SLOT_BITS+1)'(cnt_reg == '0),
                            (SLOT_BITS+1)'(cnt_reg == '0)};
                sl_we    = (cnt_reg >> SLOT_BITS) == '0;
                sl_waddr = {PAGE_BITS'(0), cnt_reg[SLOT_BITS-1:0]};
                sl_wdata = {(SLOT_BITS+1)'(cnt_reg[SLOT_BITS-1:0]) + (SLOT_BITS+1)'(1),
                            1'b0, HANDLE_BITS'(0)};
            end
            psia_pkg::S_IDLE:
            begin
                // Capture the item.
                func_next  = func;
                page_next  = id_ext[SLOT_BITS +: PAGE_BITS];
                slot_next  = id_ext[SLOT_BITS-1:0];
                hdl_next   = handle;
                rstat_next = psia_pkg::ST_NOT_FOUND;
                rid_next   = '0;
                rhdl_next  = '0;
            end
            psia_pkg::S_ISSUE:
            begin
                if (func_reg == psia_pkg::FN_ADD)
                begin
                    page_next = head_reg[PAGE_BITS-1:0];
                    pg_raddr  = head_reg[PAGE_BITS-1:0];
                    if (head_reg[PAGE_BITS])
                    begin
                        rstat_next = psia_pkg::ST_LIMIT;
                    end
                end
            end
            psia_pkg::S_PAGE:
            begin
                priority if (func_reg == psia_pkg::FN_ADD)
                begin
                    pnext_next = pr_next;
                    cnt_next   = '0;
                    if (present_reg[page_reg])
                    begin
                        puse_next = pr_use;
                        pfsh_next = pr_fsh;
                    end
                    else
                    begin
                        puse_next = '0;
                        pfsh_next = '0;
                    end
                end
                else if (func_reg == psia_pkg::FN_REMOVE)
                begin
                    if (!rm_ok)
                    begin
                        rstat_next = psia_pkg::ST_MISMATCH;
                    end
                    else
                    begin
                        // Push the slot back and relink the page if it was full.
                        rstat_next = psia_pkg::ST_OK;
                        sl_we      = 1'b1;
                        sl_wdata   = {pr_fsh, 1'b0, sr_hdl};
                        pg_we      = 1'b1;
                        pg_wdata   = {pr_next, rm_use, (SLOT_BITS+1)'(slot_reg)};
                        if (rm_wrap)
                        begin
                            pg_wdata  = {head_reg, rm_use, (SLOT_BITS+1)'(slot_reg)};
                            head_next = (PAGE_BITS+1)'(page_reg);
                            nxt_next  = head_reg;
                            pg_raddr  = head_reg[PAGE_BITS-1:0];
                        end
                        else if (page_reg != '0 && rm_use == '0
                                 && head_reg != (PAGE_BITS+1)'(page_reg))
                        begin
                            present_next[page_reg] = 1'b0;
                        end
                    end
                end
                else
                begin
                    if (sr_occ)
                    begin
                        rstat_next = psia_pkg::ST_OK;
                        rhdl_next  = hdl_ext[psia_pkg::OUT_HDL_BITS-1:0];
                    end
                end
            end
            psia_pkg::S_SWEEP:
            begin
                // Bring the page in: sequential slot links, all slots free.
                cnt_next = cnt_reg + CW'(1);
                sl_we    = 1'b1;
                sl_waddr = {page_reg, cnt_reg[SLOT_BITS-1:0]};
                sl_wdata = {(SLOT_BITS+1)'(cnt_reg[SLOT_BITS-1:0]) + (SLOT_BITS+1)'(1),
                            1'b0, HANDLE_BITS'(0)};
                if (&cnt_reg[SLOT_BITS-1:0])
                begin
                    present_next[page_reg] = 1'b1;
                end
            end
            psia_pkg::S_SLOT_RD:
            begin
                sl_raddr = {page_reg, pfsh_reg[SLOT_BITS-1:0]};
                if (pfsh_reg[SLOT_BITS])
                begin
                    rstat_next = psia_pkg::ST_LIMIT;
                end
            end
            psia_pkg::S_SLOT:
            begin
                if (sr_occ)
                begin
                    rstat_next = psia_pkg::ST_LIMIT;
                end
                else
                begin
                    // Pop the slot and store the handle.
                    rstat_next = psia_pkg::ST_OK;
                    rid_next   = asg_ext[psia_pkg::ID_BITS-1:0];
                    sl_we      = 1'b1;
                    sl_waddr   = {page_reg, pfsh_reg[SLOT_BITS-1:0]};
                    sl_wdata   = {(SLOT_BITS+1)'(SMAX), 1'b1, hdl_reg};
                    puse_next  = puse_reg + (SLOT_BITS+1)'(1);
                    pfsh_next  = sr_next;
                    if (sr_next[SLOT_BITS])
                    begin
                        head_next  = pnext_reg;
                        pnext_next = (PAGE_BITS+1)'(PMAX);
                    end
                end
            end
            psia_pkg::S_PWRITE:
            begin
                pg_we = 1'b1;
            end
            psia_pkg::S_NXT:
            begin
                // Drop the following free page if it holds nothing.
                if (nxt_reg[PAGE_BITS-1:0] != '0 && pr_use == '0)
                begin
                    present_next[nxt_reg[PAGE_BITS-1:0]] = 1'b0;
                end
            end
            psia_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    ostat_next  = rstat_reg;
                    oid_next    = rid_reg;
                    ohdl_next   = rhdl_reg;
                end
            end
            default: ;
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= psia_pkg::S_INIT;
            cnt_reg     <= '0;
            head_reg    <= '0;
            present_reg <= PMAX'(1);
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            head_reg    <= head_next;
            present_reg <= present_next;
            ovalid_reg  <= ovalid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        func_reg  <= func_next;
        page_reg  <= page_next;
        slot_reg  <= slot_next;
        hdl_reg   <= hdl_next;
        pnext_reg <= pnext_next;
        puse_reg  <= puse_next;
        pfsh_reg  <= pfsh_next;
        nxt_reg   <= nxt_next;
        rstat_reg <= rstat_next;
        rid_reg   <= rid_next;
        rhdl_reg  <= rhdl_next;
        ostat_reg <= ostat_next;
        oid_reg   <= oid_next;
        ohdl_reg  <= ohdl_next;
    end

    assign in_ready     = state_reg == psia_pkg::S_IDLE;
    assign out_valid    = ovalid_reg;
    assign status       = ostat_reg;
    assign assigned_id  = oid_reg;
    assign found_handle = ohdl_reg;

endmodule

`default_nettype wire

### rtl/paged_session_id_allocator.sv
// Top level of the paged session ID allocator: page table, slot store and sequencer.
//
// Input channel (in_valid/in_ready) carries one item: func (add, remove, find),
// session_id and handle. Output channel (out_valid/out_ready) returns one item per
// input item: status, assigned_id and found_handle.
// Items are processed one at a time by a sequencer around two synchronous RAMs:
// a page table (2**PAGE_BITS entries) and a slot store (2**(PAGE_BITS+SLOT_BITS)).
// An add that brings a page in runs the slot-link sweep of that page, one slot store
// write per cycle. The result sits in an output register; the next item is taken once
// it is loaded, so a stalled receiver holds only the item behind it.
// After reset the block runs an initialisation pass over the page table and the
// slots of page zero, with in_ready low; after it, page zero alone is present.
`default_nettype none

module paged_session_id_allocator #(
    parameter int PAGE_BITS   = 7,
    parameter int SLOT_BITS   = 9,
    parameter int HANDLE_BITS = 32
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic [1:0]                       func,
    input  wire logic [psia_pkg::ID_BITS-1:0]     session_id,
    input  wire logic [HANDLE_BITS-1:0]           handle,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic [1:0]                            status,
    output logic [psia_pkg::ID_BITS-1:0]          assigned_id,
    output logic [psia_pkg::OUT_HDL_BITS-1:0]     found_handle
);

    localparam int PW = (PAGE_BITS + 1) + 2 * (SLOT_BITS + 1);
    localparam int SW = (SLOT_BITS + 1) + 1 + HANDLE_BITS;
    localparam int SA = PAGE_BITS + SLOT_BITS;

    logic                 pg_we;
    logic [PAGE_BITS-1:0] pg_waddr;
    logic [PW-1:0]        pg_wdata;
    logic [PAGE_BITS-1:0] pg_raddr;
    logic [PW-1:0]        pg_rdata;
    logic                 sl_we;
    logic [SA-1:0]        sl_waddr;
    logic [SW-1:0]        sl_wdata;
    logic [SA-1:0]        sl_raddr;
    logic [SW-1:0]        sl_rdata;

    // Page table: next free page, use count, free-slot list head.
    psia_ram #(.ADDR_BITS(PAGE_BITS), .DATA_BITS(PW)) u_page_ram (
        .clk   (clk),
        .we    (pg_we),
        .waddr (pg_waddr),
        .wdata (pg_wdata),
        .raddr (pg_raddr),
        .rdata (pg_rdata)
    );

    // Slot store: next free slot, occupied flag, handle.
    psia_ram #(.ADDR_BITS(SA), .DATA_BITS(SW)) u_slot_ram (
        .clk   (clk),
        .we    (sl_we),
        .waddr (sl_waddr),
        .wdata (sl_wdata),
        .raddr (sl_raddr),
        .rdata (sl_rdata)
    );

    // Sequencer.
    psia_ctrl #(
        .PAGE_BITS   (PAGE_BITS),
        .SLOT_BITS   (SLOT_BITS),
        .HANDLE_BITS (HANDLE_BITS),
        .PW          (PW),
        .SW          (SW)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .session_id   (session_id),
        .handle       (handle),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .assigned_id  (assigned_id),
        .found_handle (found_handle),
        .pg_we        (pg_we),
        .pg_waddr     (pg_waddr),
        .pg_wdata     (pg_wdata),
        .pg_raddr     (pg_raddr),
        .pg_rdata     (pg_rdata),
        .sl_we        (sl_we),
        .sl_waddr     (sl_waddr),
        .sl_wdata     (sl_wdata),
        .sl_raddr     (sl_raddr),
        .sl_rdata     (sl_rdata)
    );

endmodule

`default_nettype wire

### rtl/psia_checker.sv
// Port-level checks for the allocator, bound to the top level.
`default_nettype none

module psia_checker (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             in_valid,
    input wire logic                             in_ready,
    input wire logic                             out_valid,
    input wire logic                             out_ready,
    input wire logic [1:0]                       status,
    input wire logic [psia_pkg::ID_BITS-1:0]     assigned_id,
    input wire logic [psia_pkg::OUT_HDL_BITS-1:0] found_handle
);

    // A result held back by the receiver stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result item dropped while stalled");

    // Failed operations carry no ID and no handle.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != psia_pkg::ST_OK |-> assigned_id == '0 && found_handle == '0)
        else $error("failed result carries data");

    // A given-out ID only comes with success, and never with a found handle.
    a_id_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && assigned_id != '0 |-> status == psia_pkg::ST_OK && found_handle == '0)
        else $error("assigned ID without success");

    // One item at a time: the cycle after acceptance takes nothing.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item accepted while busy");

endmodule

bind paged_session_id_allocator psia_checker u_psia_checker (.*);

`default_nettype wire
